### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RSP_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/rsp_pkg.sv
// types and constants of the rectangle subtraction block
package rsp_pkg;
	localparam int COORD_BITS = 16;
	localparam int NUM_PIECES = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [NUM_PIECES-1:0] piece_mask_t;
	typedef logic [$clog2(NUM_PIECES)-1:0] piece_idx_t;

	// fixed emit order of the candidate pieces
	localparam piece_idx_t PC_TOP    = 2'd0;
	localparam piece_idx_t PC_LEFT   = 2'd1;
	localparam piece_idx_t PC_RIGHT  = 2'd2;
	localparam piece_idx_t PC_BOTTOM = 2'd3;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} rect_t;

	typedef struct packed {
		rect_t [NUM_PIECES-1:0] rects;
		piece_mask_t            mask;
	} entry_t;
endpackage

### src/rsp_if.sv
// request channels: rectangle pairs in, pieces out
interface rsp_in_if;
	import rsp_pkg::*;
	logic   valid;
	logic   ready;
	coord_t a_left;
	coord_t a_top;
	coord_t a_right;
	coord_t a_bottom;
	coord_t b_left;
	coord_t b_top;
	coord_t b_right;
	coord_t b_bottom;
	modport source (output valid, a_left, a_top, a_right, a_bottom,
		b_left, b_top, b_right, b_bottom, input ready);
	modport sink (input valid, a_left, a_top, a_right, a_bottom,
		b_left, b_top, b_right, b_bottom, output ready);
endinterface

interface rsp_out_if;
	import rsp_pkg::*;
	logic   valid;
	logic   ready;
	coord_t out_left;
	coord_t out_top;
	coord_t out_right;
	coord_t out_bottom;
	logic   last_piece;
	modport source (output valid, out_left, out_top, out_right, out_bottom,
		last_piece, input ready);
	modport sink (input valid, out_left, out_top, out_right, out_bottom,
		last_piece, output ready);
endinterface

### src/rsp_front.sv
// front: classifies a rectangle pair into candidate pieces and a mask
module rsp_front (
	rsp_in_if.sink          pair,
	output logic            push_valid,
	output rsp_pkg::entry_t push_data,
	input  logic            push_ready
);
	import rsp_pkg::*;

	function automatic logic emit_ok(input rect_t r);
		emit_ok = (r.left <= r.right) && (r.top <= r.bottom);
	endfunction

	rect_t  rect_a;
	rect_t  cand [NUM_PIECES];
	logic   apart;
	logic   lin, tin, rin, bin;
	coord_t y0, y1;
	entry_t ent;

	always_comb begin
		rect_a = '{left: pair.a_left, top: pair.a_top,
			right: pair.a_right, bottom: pair.a_bottom};
		apart = (pair.a_right <= pair.b_left) || (pair.b_right <= pair.a_left) ||
			(pair.a_bottom <= pair.b_top) || (pair.b_bottom <= pair.a_top);
		lin = pair.a_left > pair.b_left;
		tin = pair.a_top > pair.b_top;
		rin = pair.a_right < pair.b_right;
		bin = pair.a_bottom < pair.b_bottom;
		y0 = tin ? pair.a_top : pair.b_top;
		y1 = bin ? pair.a_bottom : pair.b_bottom;

		cand[PC_TOP]    = '{left: pair.a_left, top: pair.a_top,
			right: pair.a_right, bottom: pair.b_top};
		cand[PC_LEFT]   = '{left: pair.a_left, top: y0,
			right: pair.b_left, bottom: y1};
		cand[PC_RIGHT]  = '{left: pair.b_right, top: y0,
			right: pair.a_right, bottom: y1};
		cand[PC_BOTTOM] = '{left: pair.a_left, top: pair.b_bottom,
			right: pair.a_right, bottom: pair.a_bottom};

		if (apart) begin
			// no overlap: A alone is the only candidate
			for (int i = 0; i < NUM_PIECES; i++) begin
				ent.rects[i] = rect_a;
			end
			ent.mask = '0;
			ent.mask[PC_TOP] = emit_ok(rect_a);
		end else begin
			for (int i = 0; i < NUM_PIECES; i++) begin
				ent.rects[i] = cand[i];
				ent.mask[i] = emit_ok(cand[i]);
			end
			ent.mask[PC_TOP]    = ent.mask[PC_TOP] && !tin;
			ent.mask[PC_LEFT]   = ent.mask[PC_LEFT] && !lin;
			ent.mask[PC_RIGHT]  = ent.mask[PC_RIGHT] && !rin;
			ent.mask[PC_BOTTOM] = ent.mask[PC_BOTTOM] && !bin;
		end
	end

	// pairs that leave nothing are taken and dropped here
	assign push_valid = pair.valid && (ent.mask != '0);
	assign push_data  = ent;
	assign pair.ready = push_ready;
endmodule

### src/rsp_queue.sv
// short queue of classified pairs between front and back
module rsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  rsp_pkg::entry_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output rsp_pkg::entry_t pop_data,
	input  logic            pop_ready
);
	import rsp_pkg::*;

	entry_t                 entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = count_q != QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
		if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

### src/rsp_back.sv
// back: walks the piece mask of one entry and emits a piece per cycle while the output is not stalled
module rsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  rsp_pkg::entry_t pop_data,
	output logic            pop_ready,
	rsp_out_if.source       piece
);
	import rsp_pkg::*;

	rect_t [NUM_PIECES-1:0] cur_rects_q;
	piece_mask_t            cur_mask_q;
	logic                   out_valid_q;
	rect_t                  out_rect_q;
	logic                   out_last_q;

	piece_mask_t            pick;
	piece_mask_t            rest;
	rect_t                  sel_rect;
	logic                   has;
	logic                   adv;
	logic                   pop;

	always_comb begin
		has  = cur_mask_q != '0;
		// lowest set bit keeps the fixed piece order
		pick = cur_mask_q & (~cur_mask_q + 1'b1);
		rest = cur_mask_q & ~pick;
		sel_rect = '0;
		for (int i = 0; i < NUM_PIECES; i++) begin
			if (pick[i]) begin
				sel_rect = cur_rects_q[i];
			end
		end
		adv       = has && (!out_valid_q || piece.ready);
		pop_ready = !has || (adv && (rest == '0));
		pop       = pop_valid && pop_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_mask_q <= pop_data.mask;
			end else if (adv) begin
				cur_mask_q <= rest;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (piece.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_rects_q <= pop_data.rects;
		end
		if (adv) begin
			out_rect_q <= sel_rect;
			out_last_q <= rest == '0;
		end
	end

	assign piece.valid      = out_valid_q;
	assign piece.out_left   = out_rect_q.left;
	assign piece.out_top    = out_rect_q.top;
	assign piece.out_right  = out_rect_q.right;
	assign piece.out_bottom = out_rect_q.bottom;
	assign piece.last_piece = out_last_q;
endmodule

### src/rect_subtract_pieces.sv
// top level: rectangle A minus rectangle B as up to four pieces
// path: queue entry, then back piece mask, then output register
// throughput: one piece per cycle on the output while it is not stalled; pairs
//   that leave nothing are dropped at the input and never enter the queue
// reset: clears the queue count and pointers, the piece mask and output valid
`include "assert_macros.svh"
module rect_subtract_pieces (
	input  logic      clk,
	input  logic      arst_n,
	rsp_in_if.sink    pair,
	rsp_out_if.source piece
);
	import rsp_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;
	logic   piece_upright;

	rsp_front u_front (
		.pair       (pair),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	rsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	rsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.piece     (piece)
	);

	assign piece_upright = (piece.out_left <= piece.out_right) &&
		(piece.out_top <= piece.out_bottom);

	`RSP_ASSERT_IMPL(a_queue_mask_nonzero, pop_valid, pop_data.mask != '0, "empty queued entry")
	`RSP_ASSERT_IMPL(a_piece_not_inverted, piece.valid, piece_upright, "inverted piece emitted")
	`RSP_ASSERT_NEXT(a_piece_held, piece.valid && !piece.ready, piece.valid, "stalled piece dropped")
endmodule

### tb/rect_subtract_pieces_test.sv
// self-checking testbench for the rectangle subtraction block: predicted pieces vs. actual
`timescale 1ns / 100ps

module rect_subtract_pieces_test;
	import rsp_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_PAIRS = 100;

	typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

	typedef struct {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
		logic   last;
	} piece_t;

	class piece_board;
		piece_t pending_pieces[$];
		piece_t staged[$];
		int     fails;

		function void stage_piece(coord_t l, coord_t t, coord_t r, coord_t b);
			piece_t p;
			if (l <= r && t <= b) begin
				p.left = l;
				p.top = t;
				p.right = r;
				p.bottom = b;
				p.last = 1'b0;
				staged.push_back(p);
			end
		endfunction

		// pieces of a minus b, in top, left, right, bottom order
		function void note_pair(rect_t a, rect_t b);
			coord_t al, at, ar, ab, bl, bt, br, bb, y0, y1;
			logic   l_in, t_in, r_in, b_in;
			al = a.left;
			at = a.top;
			ar = a.right;
			ab = a.bottom;
			bl = b.left;
			bt = b.top;
			br = b.right;
			bb = b.bottom;
			staged.delete();
			if (ar <= bl || br <= al || ab <= bt || bb <= at) begin
				stage_piece(al, at, ar, ab);
			end else begin
				l_in = al > bl;
				t_in = at > bt;
				r_in = ar < br;
				b_in = ab < bb;
				y0 = t_in ? at : bt;
				y1 = b_in ? ab : bb;
				if (!t_in) stage_piece(al, at, ar, bt);
				if (!l_in) stage_piece(al, y0, bl, y1);
				if (!r_in) stage_piece(br, y0, ar, y1);
				if (!b_in) stage_piece(al, bb, ar, ab);
			end
			if (staged.size() > 0)
				staged[staged.size()-1].last = 1'b1;
			foreach (staged[i])
				pending_pieces.push_back(staged[i]);
		endfunction

		function void check_piece(piece_t got);
			piece_t want;
			if (pending_pieces.size() == 0) begin
				$display("%0t  piece with no pair pending: %0d %0d %0d %0d last %0b",
					$time, got.left, got.top, got.right, got.bottom, got.last);
				fails++;
				return;
			end
			want = pending_pieces.pop_front();
			if (got.left !== want.left) begin
				$display("%0t  out_left expected %0d actual %0d", $time, want.left, got.left);
				fails++;
			end
			if (got.top !== want.top) begin
				$display("%0t  out_top expected %0d actual %0d", $time, want.top, got.top);
				fails++;
			end
			if (got.right !== want.right) begin
				$display("%0t  out_right expected %0d actual %0d", $time, want.right, got.right);
				fails++;
			end
			if (got.bottom !== want.bottom) begin
				$display("%0t  out_bottom expected %0d actual %0d",
					$time, want.bottom, got.bottom);
				fails++;
			end
			if (got.last !== want.last) begin
				$display("%0t  last_piece expected %0b actual %0b", $time, want.last, got.last);
				fails++;
			end
		endfunction

		function int waiting();
			return pending_pieces.size();
		endfunction

		function void close();
			foreach (pending_pieces[i]) begin
				$display("%0t  piece never arrived: expected %0d %0d %0d %0d last %0b actual none",
					$time, pending_pieces[i].left, pending_pieces[i].top,
					pending_pieces[i].right, pending_pieces[i].bottom, pending_pieces[i].last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rsp_in_if  pair_bus ();
	rsp_out_if piece_bus ();

	rect_subtract_pieces uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_bus),
		.piece  (piece_bus)
	);

	piece_board board;
	int send_pct;
	int recv_pct;
	int hold_req_count;
	int idle_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rect_t mk(int l, int t, int r, int b);
		rect_t x;
		x.left = coord_t'(l);
		x.top = coord_t'(t);
		x.right = coord_t'(r);
		x.bottom = coord_t'(b);
		return x;
	endfunction

	function automatic int corner();
		case ($urandom_range(9))
			0: return -32768;
			1: return 32767 - 60;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// mostly overlapping pairs with every edge on either side of b, some noise
	function automatic void random_pair(output rect_t a, output rect_t b);
		int pick, bx, by, w, h;
		pick = $urandom_range(99);
		if (pick < 12) begin
			a = {$urandom, $urandom};
			b = {$urandom, $urandom};
		end else if (pick < 22) begin
			a = mk(int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20,
				int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20);
			b = mk(int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20,
				int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20);
		end else begin
			bx = corner();
			by = corner();
			w = $urandom_range(1, 40);
			h = $urandom_range(1, 40);
			b = mk(bx, by, bx + w, by + h);
			a = mk($urandom_range(1) ? bx - int'($urandom_range(15)) : bx + int'($urandom_range(1, w)),
				$urandom_range(1) ? by - int'($urandom_range(15)) : by + int'($urandom_range(1, h)),
				$urandom_range(1) ? bx + w + int'($urandom_range(15))
					: bx + w - int'($urandom_range(1, w)),
				$urandom_range(1) ? by + h + int'($urandom_range(15))
					: by + h - int'($urandom_range(1, h)));
		end
	endfunction

	task automatic set_flow(flow_t f);
		case (f)
			FLOW_FREE: begin
				send_pct = 0;
				recv_pct = 0;
			end
			FLOW_SEND_GAPS: begin
				send_pct = 45;
				recv_pct = 0;
			end
			FLOW_RECV_STALLS: begin
				send_pct = 0;
				recv_pct = 45;
			end
			default: begin
				send_pct = 19;
				recv_pct = 19;
			end
		endcase
	endtask

	task automatic send_pair(rect_t a, rect_t b);
		@(negedge clk);
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			pair_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pair_bus.valid <= 1'b1;
		pair_bus.a_left <= a.left;
		pair_bus.a_top <= a.top;
		pair_bus.a_right <= a.right;
		pair_bus.a_bottom <= a.bottom;
		pair_bus.b_left <= b.left;
		pair_bus.b_top <= b.top;
		pair_bus.b_right <= b.right;
		pair_bus.b_bottom <= b.bottom;
		do
			@(posedge clk);
		while (!pair_bus.ready);
		board.note_pair(a, b);
	endtask

	// receiver ready, with a long hold-off whenever one is requested
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left = 0;
		piece_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_req_count) begin
				hold_served = hold_req_count;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				piece_bus.ready <= 1'b0;
			end else begin
				piece_bus.ready <= ($urandom_range(99) >= recv_pct);
			end
		end
	end

	always @(posedge clk) begin
		piece_t got;
		if (arst_n && piece_bus.valid && piece_bus.ready) begin
			got.left = piece_bus.out_left;
			got.top = piece_bus.out_top;
			got.right = piece_bus.out_right;
			got.bottom = piece_bus.out_bottom;
			got.last = piece_bus.last_piece;
			board.check_piece(got);
		end
	end

	always @(posedge clk) begin
		if ((pair_bus.valid && pair_bus.ready) || (piece_bus.valid && piece_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		rect_t a, b;
		rect_t dir_a[$], dir_b[$];
		flow_t f;
		board = new;
		idle_cycles = 0;
		hold_req_count = 0;
		arst_n = 1'b0;
		pair_bus.valid = 1'b0;
		pair_bus.a_left = '0;
		pair_bus.a_top = '0;
		pair_bus.a_right = '0;
		pair_bus.a_bottom = '0;
		pair_bus.b_left = '0;
		pair_bus.b_top = '0;
		pair_bus.b_right = '0;
		pair_bus.b_bottom = '0;
		set_flow(FLOW_FREE);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// each edge of a inside or outside b: all sixteen cases
		for (int c = 0; c < 16; c++) begin
			dir_a.push_back(mk(c[0] ? 10 : -10, c[1] ? 10 : -10, c[2] ? 90 : 110, c[3] ? 90 : 110));
			dir_b.push_back(mk(0, 0, 100, 100));
		end
		// equal rectangles, edge-touching neighbors
		dir_a.push_back(mk(0, 0, 100, 100));        dir_b.push_back(mk(0, 0, 100, 100));
		dir_a.push_back(mk(100, 0, 200, 50));       dir_b.push_back(mk(0, 0, 100, 100));
		dir_a.push_back(mk(-50, 0, 0, 50));         dir_b.push_back(mk(0, 0, 100, 100));
		dir_a.push_back(mk(0, 100, 50, 150));       dir_b.push_back(mk(0, 0, 100, 100));
		dir_a.push_back(mk(0, -50, 50, 0));         dir_b.push_back(mk(0, 0, 100, 100));
		// extremes of the coordinate range
		dir_a.push_back(mk(-32768, -32768, 32767, 32767)); dir_b.push_back(mk(-5, -5, 5, 5));
		dir_a.push_back(mk(-5, -5, 5, 5));          dir_b.push_back(mk(-32768, -32768, 32767, 32767));
		// inverted a, inverted b, zero-width a apart from b
		dir_a.push_back(mk(32767, 32767, -32768, -32768)); dir_b.push_back(mk(0, 0, 100, 100));
		dir_a.push_back(mk(0, 0, 100, 100));        dir_b.push_back(mk(80, 20, 20, 80));
		dir_a.push_back(mk(300, 300, 300, 350));    dir_b.push_back(mk(0, 0, 100, 100));
		foreach (dir_a[i])
			send_pair(dir_a[i], dir_b[i]);

		for (int ph = 0; ph < 4; ph++) begin
			f = flow_t'(ph);
			set_flow(f);
			// block fills while the sender keeps offering pairs
			if (f == FLOW_FREE)
				hold_req_count++;
			repeat (PHASE_PAIRS) begin
				random_pair(a, b);
				send_pair(a, b);
			end
		end
		@(negedge clk);
		pair_bus.valid <= 1'b0;

		while (board.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.close();
		if (board.fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### sim.f
+incdir+src
src/rsp_pkg.sv
src/rsp_if.sv
src/rsp_front.sv
src/rsp_queue.sv
src/rsp_back.sv
src/rect_subtract_pieces.sv
tb/rect_subtract_pieces_test.sv
